// ===== src/hbp_pkg.sv =====
`timescale 1ns / 1ps
package hbp_pkg;

  localparam int CODE_W   = 32;
  localparam int LEN_FW   = 6;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 24;
  localparam int REM_W    = 6;
  localparam int WIN_W    = CODE_W + BYTE_W;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_ENCODE = 1'b1
  } func_t;

  // looked-up encode beat, left-aligned code
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              hit;
    logic [CODE_W-1:0] code;
    logic [LEN_FW-1:0] len;
  } lookup_t;

endpackage

// ===== src/hbp_table.sv =====
`timescale 1ns / 1ps
module hbp_table #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      ld_en,
  input  logic                      enc_en,
  input  logic [7:0]                symbol,
  input  logic [hbp_pkg::CODE_W-1:0] code_value,
  input  logic [hbp_pkg::LEN_FW-1:0] code_length,
  input  logic                      last,
  input  logic                      take,
  output hbp_pkg::lookup_t          lk
);
  import hbp_pkg::*;

  localparam int CAP    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int LEN_W  = $clog2(CAP + 1);
  localparam int ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  logic [CODE_W-1:0] mem_code [SYMBOL_COUNT];
  logic [LEN_W-1:0]  mem_len  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] used_r, used_nxt;

  logic [ADDR_W-1:0] addr;
  logic              in_range;
  logic [LEN_FW-1:0] len_cap;
  logic [CODE_W-1:0] code_left;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_last_r;
  logic              s1_used_r;
  logic [CODE_W-1:0] rd_code_r;
  logic [LEN_W-1:0]  rd_len_r;

  assign addr     = symbol[ADDR_W-1:0];
  assign in_range = (9'(symbol) < 9'(SYMBOL_COUNT));
  assign len_cap  = (code_length > LEN_FW'(CAP)) ? LEN_FW'(CAP) : code_length;
  // store the code left-aligned so the packer only shifts by the pending count
  assign code_left = code_value << (LEN_FW'(CODE_W) - len_cap);

  always_ff @(posedge clk) begin
    if (ld_en && in_range) begin
      mem_code[addr] <= code_left;
      mem_len[addr]  <= len_cap[LEN_W-1:0];
    end
    if (enc_en) begin
      rd_code_r <= mem_code[addr];
      rd_len_r  <= mem_len[addr];
      s1_last_r <= last;
      s1_used_r <= used_r[addr] && in_range;
    end
  end

  always_comb begin
    used_nxt = used_r;
    if (ld_en && in_range) begin
      used_nxt[addr] = 1'b1;
    end
    s1_valid_nxt = s1_valid_r;
    if (enc_en) begin
      s1_valid_nxt = 1'b1;
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      used_r     <= used_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  assign lk.valid = s1_valid_r;
  assign lk.last  = s1_last_r;
  assign lk.hit   = s1_used_r && (rd_len_r != '0);
  assign lk.code  = rd_code_r;
  assign lk.len   = LEN_FW'(rd_len_r);

endmodule

// ===== src/hbp_packer.sv =====
`timescale 1ns / 1ps
module hbp_packer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hbp_pkg::lookup_t            lk,
  output logic                        take,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hbp_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_end,
  output logic                        out_err,
  output logic [hbp_pkg::COUNT_W-1:0] out_count
);
  import hbp_pkg::*;

  logic [WIN_W-1:0]   win_r, win_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic               last_r, last_nxt;
  logic               err_r, err_nxt;
  logic               disc_r, disc_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;

  logic               ov_r, ov_nxt;
  logic [BYTE_W-1:0]  ob_r, ob_nxt;
  logic               oe_r, oe_nxt;
  logic               oerr_r, oerr_nxt;
  logic [COUNT_W-1:0] oc_r, oc_nxt;

  logic               out_free, emit, is_final;
  logic [REM_W-1:0]   rem_after;
  logic [WIN_W-1:0]   win_after;
  logic               err_after, last_after, idle_after;
  logic [COUNT_W-1:0] cnt_inc;

  always_comb begin
    out_free = !ov_r || out_ready;
    emit     = out_free && (err_r || (rem_r >= REM_W'(BYTE_W)) ||
                            (last_r && (rem_r != '0)));
    is_final = err_r || (last_r && (rem_r <= REM_W'(BYTE_W)));
    cnt_inc  = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + COUNT_W'(1);

    if (emit && !err_r) begin
      rem_after = (rem_r > REM_W'(BYTE_W)) ? rem_r - REM_W'(BYTE_W) : '0;
      win_after = win_r << BYTE_W;
    end else begin
      rem_after = rem_r;
      win_after = win_r;
    end
    err_after  = err_r && !emit;
    last_after = last_r && !(emit && is_final);
    idle_after = !err_after && !last_after && (rem_after < REM_W'(BYTE_W));
    take       = lk.valid && idle_after;

    win_nxt  = win_after;
    rem_nxt  = rem_after;
    err_nxt  = err_after;
    last_nxt = last_after;
    disc_nxt = disc_r;
    cnt_nxt  = cnt_r;

    ov_nxt   = ov_r && !out_ready;
    ob_nxt   = ob_r;
    oe_nxt   = oe_r;
    oerr_nxt = oerr_r;
    oc_nxt   = oc_r;

    if (emit) begin
      ov_nxt   = 1'b1;
      ob_nxt   = err_r ? '0 : win_r[WIN_W-1 -: BYTE_W];
      oe_nxt   = is_final;
      oerr_nxt = err_r;
      oc_nxt   = (!err_r && is_final) ? cnt_inc : '0;
      if (!err_r) begin
        cnt_nxt = is_final ? '0 : cnt_inc;
      end
    end

    if (take) begin
      if (disc_r) begin
        // drop until the end of the text
        if (lk.last) begin
          disc_nxt = 1'b0;
        end
      end else if (!lk.hit) begin
        err_nxt  = 1'b1;
        win_nxt  = '0;
        rem_nxt  = '0;
        cnt_nxt  = '0;
        disc_nxt = !lk.last;
      end else begin
        win_nxt  = win_after | ({lk.code, {BYTE_W{1'b0}}} >> rem_after);
        rem_nxt  = rem_after + lk.len;
        last_nxt = lk.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    ob_r   <= ob_nxt;
    oe_r   <= oe_nxt;
    oerr_r <= oerr_nxt;
    oc_r   <= oc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      rem_r  <= '0;
      last_r <= 1'b0;
      err_r  <= 1'b0;
      disc_r <= 1'b0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      win_r  <= win_nxt;
      rem_r  <= rem_nxt;
      last_r <= last_nxt;
      err_r  <= err_nxt;
      disc_r <= disc_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_end   = oe_r;
  assign out_err   = oerr_r;
  assign out_count = oc_r;

endmodule

// ===== src/huffman_bit_packer_top.sv =====
`timescale 1ns / 1ps
// Huffman encoder with MSB-first byte packing. Load beats (tuser = 0) write a
// symbol's right-aligned code and length into a code table with a registered
// read; entry flags cleared by reset mark every symbol absent at once, with no
// clearing sweep. Encode beats (tuser = 1) read the table in the accept cycle
// and reach the packer in the cycle after. The packer takes a looked-up code
// once fewer than 8 bits are left to send and no final or error byte is
// pending, and sends one byte per cycle through a registered output while
// out_tready allows, so the input is held while a full byte, or a final or
// error byte, is still pending; short codes stream at one beat per cycle when
// neither side stalls.
// A missing code gives one tlast beat with tuser set and zero data, and the
// rest of the text up to its tlast is dropped. Output tdata carries the byte
// count, saturating at 2^24-1, on tlast beats only.
module huffman_bit_packer_top #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] symbol, [39:8] code_value, [45:40] code_length, [47:46] zero
  input  logic [hbp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] func
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] out_byte, [31:8] byte_count
  output logic [hbp_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] error
  output logic                            out_tuser,
  output logic                            out_tlast
);
  import hbp_pkg::*;

  logic               in_acc, ld_en, enc_en, take;
  lookup_t            lk;
  logic [BYTE_W-1:0]  o_byte;
  logic [COUNT_W-1:0] o_count;

  assign in_acc    = in_tvalid && in_tready;
  assign ld_en     = in_acc && (func_t'(in_tuser) == FUNC_LOAD);
  assign enc_en    = in_acc && (func_t'(in_tuser) == FUNC_ENCODE);
  assign in_tready = !lk.valid || take;

  hbp_table #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld_en      (ld_en),
    .enc_en     (enc_en),
    .symbol     (in_tdata[7:0]),
    .code_value (in_tdata[39:8]),
    .code_length(in_tdata[45:40]),
    .last       (in_tlast),
    .take       (take),
    .lk         (lk)
  );

  hbp_packer u_packer (
    .clk      (clk),
    .rst_n    (rst_n),
    .lk       (lk),
    .take     (take),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_byte (o_byte),
    .out_end  (out_tlast),
    .out_err  (out_tuser),
    .out_count(o_count)
  );

  assign out_tdata = {o_count, o_byte};

endmodule

// ===== src/hbp_checker.sv =====
`timescale 1ns / 1ps
module hbp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hbp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);
  import hbp_pkg::*;

  a_err_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("error beat without tlast");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error beat carries data");

  a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[OUT_TDATA_W-1:BYTE_W] == '0)
    else $error("byte count on a non-final beat");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled beat changed");

endmodule

bind huffman_bit_packer_top hbp_checker u_hbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

// ===== dv/huffman_bit_packer_top_tb.sv =====
`timescale 1ns / 1ps
module huffman_bit_packer_top_tb;
  import hbp_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_BEATS = 460;
  localparam int LEN_CAP = 32;

  typedef struct {
    func_t             func;
    logic [7:0]        sym;
    logic [CODE_W-1:0] code;
    logic [LEN_FW-1:0] len;
    logic              last;
  } symbol_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic               eor;
    logic               err;
    logic [COUNT_W-1:0] count;
  } packed_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  huffman_bit_packer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #6 clk = ~clk;

  symbol_beat_t symbol_beats_q[$];
  packed_byte_t packed_bytes_q[$];

  // encoder shadow state
  logic [CODE_W-1:0]  code_mem [256];
  int                 len_mem  [256];
  logic [BYTE_W-1:0]  acc;
  int                 acc_bits;
  logic [COUNT_W-1:0] text_bytes;
  logic               dropping;

  // stimulus-side view of which symbols have a code
  int gen_len [256];

  int beats_in;
  int bytes_checked;
  int texts_seen;
  int error_ends;
  int failures;
  int cycles = 0;

  function automatic bit idle_now();
    // no idling at all through a middle stretch of the run
    if (beats_in >= 160 && beats_in < 300) return 1'b0;
    return $urandom_range(0, 99) < 37;
  endfunction

  task automatic count_packed_byte();
    if (text_bytes != COUNT_MAX) text_bytes = text_bytes + 1'b1;
  endtask

  task automatic pack_symbol(input symbol_beat_t b);
    int n;
    int i;
    n = 0;
    if (b.func == FUNC_LOAD) begin
      code_mem[b.sym] = b.code;
      len_mem[b.sym] = (b.len > LEN_CAP) ? LEN_CAP : int'(b.len);
      return;
    end
    if (dropping) begin
      if (b.last) dropping = 1'b0;
      return;
    end
    if (len_mem[b.sym] == 0) begin
      packed_bytes_q.push_back('{data: '0, eor: 1'b1, err: 1'b1, count: '0});
      acc = '0;
      acc_bits = 0;
      text_bytes = '0;
      dropping = !b.last;
      return;
    end
    for (i = len_mem[b.sym] - 1; i >= 0; i--) begin
      acc = {acc[BYTE_W-2:0], code_mem[b.sym][i]};
      acc_bits++;
      if (acc_bits == BYTE_W) begin
        count_packed_byte();
        packed_bytes_q.push_back('{data: acc, eor: 1'b0, err: 1'b0, count: '0});
        n++;
        acc = '0;
        acc_bits = 0;
      end
    end
    if (b.last) begin
      if (acc_bits != 0) begin
        count_packed_byte();
        packed_bytes_q.push_back('{data: acc << (BYTE_W - acc_bits), eor: 1'b0, err: 1'b0,
                                   count: '0});
        n++;
      end
      if (n > 0) begin
        packed_bytes_q[packed_bytes_q.size()-1].eor = 1'b1;
        packed_bytes_q[packed_bytes_q.size()-1].count = text_bytes;
      end
      acc = '0;
      acc_bits = 0;
      text_bytes = '0;
    end
  endtask

  task automatic push_load(input logic [7:0] sym, input logic [CODE_W-1:0] code,
                           input logic [LEN_FW-1:0] len, input logic last);
    symbol_beats_q.push_back('{func: FUNC_LOAD, sym: sym, code: code, len: len, last: last});
    gen_len[sym] = (len > LEN_CAP) ? LEN_CAP : int'(len);
  endtask

  task automatic push_encode(input logic [7:0] sym, input logic last);
    symbol_beats_q.push_back('{func: FUNC_ENCODE, sym: sym, code: $urandom(),
                               len: LEN_FW'($urandom_range(0, 63)), last: last});
  endtask

  function automatic logic [LEN_FW-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 68) return LEN_FW'($urandom_range(1, 8));
    if (r < 90) return LEN_FW'($urandom_range(9, 20));
    if (r < 98) return LEN_FW'($urandom_range(21, 32));
    return LEN_FW'($urandom_range(33, 63));
  endfunction

  task automatic push_random_load();
    logic [7:0] sym;
    logic [LEN_FW-1:0] len;
    sym = 8'($urandom_range(0, 255));
    len = ($urandom_range(0, 99) < 15 && sym != 8'h00) ? '0 : pick_len();
    push_load(sym, $urandom(), len, 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [7:0] pick_coded_symbol();
    logic [7:0] sym;
    // symbol 0 always keeps a code, so this terminates
    do sym = 8'($urandom_range(0, 255)); while (gen_len[sym] == 0);
    return sym;
  endfunction

  // driver: present queued beats, predict on accept
  symbol_beat_t cur_beat;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pack_symbol(cur_beat);
        beats_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (symbol_beats_q.size() != 0 && !idle_now()) begin
          cur_beat = symbol_beats_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_beat.func;
          in_tlast  <= cur_beat.last;
          in_tdata  <= {2'b00, cur_beat.len, cur_beat.code, cur_beat.sym};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check every output beat against the oldest prediction
  always @(posedge clk) begin : monitor
    packed_byte_t got;
    packed_byte_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !idle_now();
      if (out_tvalid && out_tready) begin
        got = '{data: out_tdata[BYTE_W-1:0], eor: out_tlast, err: out_tuser,
                count: out_tdata[BYTE_W +: COUNT_W]};
        if (got.eor) texts_seen++;
        if (got.err) error_ends++;
        if (packed_bytes_q.size() == 0) begin
          failures++;
          $display("%0t: unexpected output beat data=%02h last=%0b err=%0b count=%0d",
                   $time, got.data, got.eor, got.err, got.count);
        end else begin
          want = packed_bytes_q.pop_front();
          bytes_checked++;
          if (got.data !== want.data || got.eor !== want.eor || got.err !== want.err ||
              got.count !== want.count) begin
            failures++;
            $display("%0t: mismatch expected data=%02h last=%0b err=%0b count=%0d",
                     $time, want.data, want.eor, want.err, want.count);
            $display("%0t:          actual   data=%02h last=%0b err=%0b count=%0d",
                     $time, got.data, got.eor, got.err, got.count);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("huffman_bit_packer_top_tb failed");
      $finish;
    end
  end

  initial begin
    int k;
    int j;
    beats_in = 0;
    bytes_checked = 0;
    texts_seen = 0;
    error_ends = 0;
    failures = 0;
    acc = '0;
    acc_bits = 0;
    text_bytes = '0;
    dropping = 1'b0;
    foreach (len_mem[i]) begin
      len_mem[i] = 0;
      code_mem[i] = '0;
      gen_len[i] = 0;
    end

    // directed
    push_encode(8'h07, 1'b1);                      // never loaded, ends the text
    push_load(8'h00, 32'hFFFF_FFFE, 6'd1, 1'b0);   // one-bit code, junk above it
    push_load(8'hFF, 32'hFFFF_FFFF, 6'd32, 1'b1);  // last flag on a load is ignored
    push_load(8'h55, 32'h0000_0005, 6'd3, 1'b0);
    push_load(8'h80, 32'h8000_0001, 6'd63, 1'b0);  // saturates to 32 bits
    push_load(8'h2A, 32'hDEAD_BEEF, 6'd0, 1'b0);   // absent
    push_encode(8'h00, 1'b1);                      // padded single byte
    push_encode(8'hFF, 1'b0);
    push_encode(8'hFF, 1'b1);                      // ends on a byte boundary
    push_encode(8'h55, 1'b0);
    push_encode(8'h55, 1'b0);
    push_encode(8'h55, 1'b1);
    push_encode(8'h80, 1'b1);
    push_encode(8'h55, 1'b0);
    push_encode(8'h2A, 1'b0);                      // absent mid-text, drop the rest
    push_encode(8'hFF, 1'b0);
    push_load(8'h2A, 32'h0000_0003, 6'd2, 1'b0);   // loads still land while dropping
    push_encode(8'h2A, 1'b1);
    push_encode(8'h2A, 1'b0);
    push_encode(8'h2A, 1'b1);
    push_load(8'h55, 32'h0000_0005, 6'd0, 1'b0);   // remove a code
    push_encode(8'h55, 1'b1);

    // random: build a table, then mostly well-formed texts
    for (k = 0; k < 40; k++) push_random_load();
    while (symbol_beats_q.size() < 22 + RANDOM_BEATS) begin
      if ($urandom_range(0, 99) < 8) begin
        push_random_load();
      end else begin
        k = $urandom_range(1, 12);
        for (j = 0; j < k; j++) begin
          if ($urandom_range(0, 99) < 4) push_random_load();
          if ($urandom_range(0, 99) < 3)
            push_encode(8'($urandom_range(0, 255)), j == k - 1);
          else
            push_encode(pick_coded_symbol(), j == k - 1);
        end
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (symbol_beats_q.size() != 0 || in_tvalid) @(negedge clk);
    while (packed_bytes_q.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);

    $display("Fed %0d symbol and table beats; checked %0d packed bytes across %0d texts,",
             beats_in, bytes_checked, texts_seen);
    $display("%0d of which ended on a missing code, with random stalls on both sides.",
             error_ends);
    if (failures == 0) begin
      $display("huffman_bit_packer_top_tb passed");
    end else begin
      $display("huffman_bit_packer_top_tb failed");
    end
    $finish;
  end

endmodule
